@@ rtl/scale_degree_pitch_mapper_macros.svh @@
// Assertion macros used by the checker file of the pitch mapper.
`ifndef SCALE_DEGREE_PITCH_MAPPER_MACROS_SVH
`define SCALE_DEGREE_PITCH_MAPPER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define SDPM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pitch mapper assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SDPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pitch mapper assertion failed");

`endif

@@ rtl/sdpm_pkg.sv @@
// Package with types, register indexes and degree tables of the pitch mapper.
`default_nettype none

package sdpm_pkg;

    localparam int NUM_ROWS = 20;
    localparam int DEG_SLOTS = 12;
    localparam int CHROM_BASE = 60;
    localparam int PITCH_MAX = 127;
    localparam int CHROM_TOP = 11;
    localparam int OCTAVE = 12;

    localparam logic [2:0] REG_SCALE_SELECT  = 3'd0;
    localparam logic [2:0] REG_SPREAD        = 3'd1;
    localparam logic [2:0] REG_ROOT_NOTE     = 3'd2;
    localparam logic [2:0] REG_MODE_ROTATION = 3'd3;
    localparam logic [2:0] REG_OCTAVE_OFFSET = 3'd4;
    localparam logic [2:0] REG_KEY_OFFSET    = 3'd5;

    // Distinct degrees of each scale map, padded with zeros.
    localparam logic [3:0] DEG_TABLE [NUM_ROWS][DEG_SLOTS] = '{
        '{4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd9, 4'd10, 4'd11},
        '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd8, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd3, 4'd5, 4'd6, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd3, 4'd4, 4'd7, 4'd9, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd5, 4'd7, 4'd9, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd5, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd1, 4'd5, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd7, 4'd9, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd1, 4'd3, 4'd5, 4'd6, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd3, 4'd6, 4'd7, 4'd9, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd4, 4'd5, 4'd7, 4'd9, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd1, 4'd3, 4'd7, 4'd8, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd5, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd3, 4'd5, 4'd6, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd2, 4'd4, 4'd7, 4'd9, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd3, 4'd5, 4'd7, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd0, 4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
    };

    localparam logic [3:0] DEG_COUNT [NUM_ROWS] = '{
        4'd12, 4'd7, 4'd7, 4'd7, 4'd6, 4'd6, 4'd7, 4'd5, 4'd5, 4'd5,
        4'd7, 4'd7, 4'd7, 4'd7, 4'd5, 4'd5, 4'd6, 4'd5, 4'd5, 4'd7
    };

    typedef struct packed {
        logic              chrom;
        logic [4:0]        row;
        logic [3:0]        spread;
        logic [3:0]        step;
        logic [6:0]        root;
        logic signed [4:0] rot;
        logic signed [6:0] oct;
        logic signed [5:0] key;
    } cfg_t;

endpackage

`default_nettype wire

@@ rtl/sdpm_pipe.sv @@
// Four-stage datapath that turns a button position into a saturated pitch.
`default_nettype none

module sdpm_pipe (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire sdpm_pkg::cfg_t cfg,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [4:0]    button_pos,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [6:0]         midi_pitch,
    output logic               clamped
);

    typedef struct packed {
        logic       chrom;
        logic [4:0] row;
        logic [3:0] n;
        logic [3:0] r;
        logic [8:0] prod;
    } s1_t;

    typedef struct packed {
        logic       chrom;
        logic [4:0] row;
        logic [3:0] n;
        logic [3:0] r;
        logic [8:0] prod;
        logic [6:0] rem;
        logic [3:0] qh;
    } s2_t;

    typedef struct packed {
        logic       chrom;
        logic [4:0] row;
        logic [3:0] r;
        logic [8:0] prod;
        logic [6:0] q;
        logic [3:0] rot;
    } s3_t;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    s3_t  s3_reg, s3_next;
    logic [6:0] pitch_reg, pitch_next;
    logic       clamped_reg, clamped_next;

    assign en4 = !v4_reg || out_ready;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ready = en1;
    assign out_valid = v4_reg;
    assign midi_pitch = pitch_reg;
    assign clamped = clamped_reg;

    // Stage 1: one multiply and the rotation reduced modulo the degree count.
    always_comb
    begin
        logic [3:0] n;
        logic [3:0] idx;
        logic [4:0] mul_a;
        logic [3:0] mul_b;
        logic [6:0] rem;
        logic [6:0] dvs;
        n = sdpm_pkg::DEG_COUNT[cfg.row];
        idx = (button_pos > 5'(sdpm_pkg::CHROM_TOP)) ? 4'(sdpm_pkg::CHROM_TOP)
                                                      : button_pos[3:0];
        mul_a = cfg.chrom ? {1'b0, idx} : button_pos;
        mul_b = cfg.chrom ? cfg.spread : cfg.step;
        rem = 7'({n, 2'b00}) + 7'(6'(cfg.rot));
        rem = {1'b0, rem[5:0]};
        for (int k = 3; k >= 0; k--)
        begin
            dvs = 7'(n) << k;
            if (rem >= dvs)
            begin
                rem = rem - dvs;
            end
        end
        s1_next.chrom = cfg.chrom;
        s1_next.row = cfg.row;
        s1_next.n = n;
        s1_next.r = rem[3:0];
        s1_next.prod = 9'(mul_a) * 9'(mul_b);
    end

    // Stage 2: upper quotient bits of the stepped position over the count.
    always_comb
    begin
        logic [9:0] rem;
        logic [9:0] dvs;
        logic [3:0] qh;
        rem = 10'(s1_reg.prod) + 10'(s1_reg.r);
        qh = '0;
        for (int k = 6; k >= 3; k--)
        begin
            dvs = 10'(s1_reg.n) << k;
            if (rem >= dvs)
            begin
                rem = rem - dvs;
                qh[k - 3] = 1'b1;
            end
        end
        s2_next.chrom = s1_reg.chrom;
        s2_next.row = s1_reg.row;
        s2_next.n = s1_reg.n;
        s2_next.r = s1_reg.r;
        s2_next.prod = s1_reg.prod;
        s2_next.rem = rem[6:0];
        s2_next.qh = qh;
    end

    // Stage 3: lower quotient bits and the rotated degree index.
    always_comb
    begin
        logic [6:0] rem;
        logic [6:0] dvs;
        logic [2:0] ql;
        rem = s2_reg.rem;
        ql = '0;
        for (int k = 2; k >= 0; k--)
        begin
            dvs = 7'(s2_reg.n) << k;
            if (rem >= dvs)
            begin
                rem = rem - dvs;
                ql[k] = 1'b1;
            end
        end
        s3_next.chrom = s2_reg.chrom;
        s3_next.row = s2_reg.row;
        s3_next.r = s2_reg.r;
        s3_next.prod = s2_reg.prod;
        s3_next.q = {s2_reg.qh, ql};
        s3_next.rot = rem[3:0];
    end

    // Stage 4: degree lookup, offsets and saturation.
    always_comb
    begin
        logic [10:0]       q12;
        logic signed [11:0] rdeg;
        logic signed [11:0] pitch;
        q12 = (11'(s3_reg.q) << 3) + (11'(s3_reg.q) << 2);
        rdeg = signed'(12'(q12))
            + signed'(12'(sdpm_pkg::DEG_TABLE[s3_reg.row][s3_reg.rot]))
            - signed'(12'(sdpm_pkg::DEG_TABLE[s3_reg.row][s3_reg.r]));
        if (rdeg < 0)
        begin
            rdeg = rdeg + 12'(sdpm_pkg::OCTAVE);
        end
        if (s3_reg.chrom)
        begin
            pitch = 12'(sdpm_pkg::CHROM_BASE) + signed'(12'(s3_reg.prod))
                + 12'(cfg.key) + 12'(cfg.oct);
        end
        else
        begin
            pitch = signed'(12'(cfg.root)) + rdeg + 12'(cfg.oct);
        end
        if (pitch < 0)
        begin
            pitch_next = '0;
            clamped_next = 1'b1;
        end
        else if (pitch > 12'(sdpm_pkg::PITCH_MAX))
        begin
            pitch_next = 7'(sdpm_pkg::PITCH_MAX);
            clamped_next = 1'b1;
        end
        else
        begin
            pitch_next = pitch[6:0];
            clamped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg <= s1_next;
        end
        if (en2)
        begin
            s2_reg <= s2_next;
        end
        if (en3)
        begin
            s3_reg <= s3_next;
        end
        if (en4)
        begin
            pitch_reg <= pitch_next;
            clamped_reg <= clamped_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/scale_degree_pitch_mapper.sv @@
// Top level of the scale degree pitch mapper: configuration registers and datapath.
//
//  channel  | handshake             | word
//  ---------+-----------------------+-------------------------
//  input    | in_valid / in_ready   | button_pos
//  output   | out_valid / out_ready | midi_pitch, clamped
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A word passes from input to output through four register stages: multiply, two
// halves of the division by the degree count, and the table lookup with saturation.
// One word enters every cycle unless out_ready has stalled the full stages.
// Reset clears the stage valid bits and loads the register defaults.
// A stall holds each full stage; empty stages keep filling behind it.
// Configuration writes are always accepted.
`default_nettype none

module scale_degree_pitch_mapper #(
    parameter int NUM_SCALES = 20
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [4:0] button_pos,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [6:0]      midi_pitch,
    output logic            clamped,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [2:0] cfg_index,
    input  wire logic [6:0] cfg_data
);

    logic [4:0]        scale_select_reg;
    logic [3:0]        spread_reg;
    logic [6:0]        root_note_reg;
    logic signed [4:0] mode_rotation_reg;
    logic signed [6:0] octave_offset_reg;
    logic signed [5:0] key_offset_reg;
    logic              in_table;
    sdpm_pkg::cfg_t    cfg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_select_reg <= 5'd0;
            spread_reg <= 4'd1;
            root_note_reg <= 7'd60;
            mode_rotation_reg <= 5'sd0;
            octave_offset_reg <= 7'sd0;
            key_offset_reg <= 6'sd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                sdpm_pkg::REG_SCALE_SELECT:  scale_select_reg <= cfg_data[4:0];
                sdpm_pkg::REG_SPREAD:        spread_reg <= cfg_data[3:0];
                sdpm_pkg::REG_ROOT_NOTE:     root_note_reg <= cfg_data;
                sdpm_pkg::REG_MODE_ROTATION: mode_rotation_reg <= signed'(cfg_data[4:0]);
                sdpm_pkg::REG_OCTAVE_OFFSET: octave_offset_reg <= signed'(cfg_data);
                sdpm_pkg::REG_KEY_OFFSET:    key_offset_reg <= signed'(cfg_data[5:0]);
                default:
                begin
                end
            endcase
        end
    end

    // Scales without a map fall back to the twelve chromatic degrees of row zero.
    assign in_table = (scale_select_reg != 5'd0)
        && ({1'b0, scale_select_reg} < 6'(NUM_SCALES))
        && (scale_select_reg < 5'(sdpm_pkg::NUM_ROWS));

    always_comb
    begin
        cfg.chrom = (scale_select_reg == 5'd0);
        cfg.row = in_table ? scale_select_reg : 5'd0;
        cfg.spread = spread_reg;
        cfg.step = (spread_reg == 4'd0) ? 4'd1 : spread_reg;
        cfg.root = root_note_reg;
        cfg.rot = mode_rotation_reg;
        cfg.oct = octave_offset_reg;
        cfg.key = key_offset_reg;
    end

    sdpm_pipe u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .button_pos (button_pos),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .midi_pitch (midi_pitch),
        .clamped    (clamped)
    );

endmodule

`default_nettype wire

@@ rtl/sdpm_checker.sv @@
// Port checker for the pitch mapper and its bind to the top level.
`default_nettype none

`include "scale_degree_pitch_mapper_macros.svh"

module sdpm_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [6:0] midi_pitch,
    input wire logic       clamped
);

    logic [2:0] occ_reg, occ_next;

    always_comb
    begin
        occ_next = occ_reg + 3'((in_valid && in_ready) ? 1 : 0)
            - 3'((out_valid && out_ready) ? 1 : 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    `SDPM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(midi_pitch) && $stable(clamped))
    `SDPM_ASSERT_IMPLY(a_clamp_edge, clk, rst_n, out_valid && clamped, midi_pitch == 7'd0 || midi_pitch == 7'd127)
    `SDPM_ASSERT_IMPLY(a_out_has_word, clk, rst_n, out_valid, occ_reg != 3'd0)
    `SDPM_ASSERT_IMPLY(a_occ_bound, clk, rst_n, 1'b1, occ_reg <= 3'd4)
    `SDPM_ASSERT_IMPLY(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

endmodule

bind scale_degree_pitch_mapper sdpm_checker u_sdpm_checker (.*);

`default_nettype wire
